// ===== src/iida_pkg.sv =====
// Shared types and constants for the interval ID allocator.
package iida_pkg;

  // Request codes carried in the low bits of the input word
  typedef enum logic [1:0] {
    FN_GENERATE = 2'd0,
    FN_QUERY    = 2'd1,
    FN_RESERVE  = 2'd2,
    FN_RELEASE  = 2'd3
  } func_t;

  // Update applied to the cell row in the execute cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_GEN_INC,
    OP_GEN_DROP,
    OP_RES_INC,
    OP_RES_DEC,
    OP_RES_DROP,
    OP_RES_SPLIT,
    OP_REL_MERGE,
    OP_REL_PREV,
    OP_REL_NEXT,
    OP_REL_INS
  } cell_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // Broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t op;
    logic     capture;
  } cell_cmd_t;

  // What a cell shows its neighbours
  typedef struct packed {
    logic valid;
    logic below;
    logic hit;
    logic above;
  } cell_link_t;

  // Per-cell findings, OR-reduced across the row for the controller
  typedef struct packed {
    logic hit;
    logic lo_hit;
    logic hi_hit;
    logic prev_ok;
    logic next_ok;
  } cell_report_t;

  localparam int FUNC_W     = 2;
  localparam int ID_W       = 32;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;

endpackage

// ===== src/iida_cell.sv =====
// One cell of the free-interval row: holds one interval and its compare flags.
module iida_cell #(
  parameter int ID_BITS = 32,
  parameter bit FIRST   = 1'b0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  iida_pkg::cell_cmd_t       cmd,
  input  logic [ID_BITS-1:0]        key,
  input  iida_pkg::cell_link_t      left,
  input  logic [ID_BITS-1:0]        left_lo,
  input  logic [ID_BITS-1:0]        left_hi,
  input  iida_pkg::cell_link_t      right,
  input  logic [ID_BITS-1:0]        right_lo,
  input  logic [ID_BITS-1:0]        right_hi,
  output iida_pkg::cell_link_t      link,
  output logic [ID_BITS-1:0]        lo,
  output logic [ID_BITS-1:0]        hi,
  output iida_pkg::cell_report_t    report
);

  localparam logic [ID_BITS-1:0] ONE   = {{(ID_BITS-1){1'b0}}, 1'b1};
  localparam logic [ID_BITS:0]   ONE_X = {{ID_BITS{1'b0}}, 1'b1};

  logic               vld;
  logic [ID_BITS-1:0] lo_q;
  logic [ID_BITS-1:0] hi_q;
  logic               below_q;
  logic               hit_q;
  logic               above_q;
  logic               lo_eq_q;
  logic               hi_eq_q;
  logic               nadj_q;
  logic               padj_q;

  logic               vld_next;
  logic [ID_BITS-1:0] lo_next;
  logic [ID_BITS-1:0] hi_next;
  logic               is_p;
  logic               is_pm1;

  // Place of this cell relative to the key: last interval below it, first above it
  assign is_pm1 = below_q & right.above;
  assign is_p   = above_q & left.below;

  assign link.valid = vld;
  assign link.below = below_q;
  assign link.hit   = hit_q;
  assign link.above = above_q;
  assign lo         = lo_q;
  assign hi         = hi_q;

  assign report.hit     = hit_q;
  assign report.lo_hit  = hit_q & lo_eq_q;
  assign report.hi_hit  = hit_q & hi_eq_q;
  assign report.prev_ok = is_pm1 & padj_q;
  assign report.next_ok = is_p & vld & nadj_q;

  // Work out the new interval from own contents or a neighbour's
  always_comb begin
    vld_next = vld;
    lo_next  = lo_q;
    hi_next  = hi_q;
    unique case (cmd.op)
      iida_pkg::OP_NONE: ;
      iida_pkg::OP_GEN_INC: begin
        if (FIRST) begin
          lo_next = lo_q + ONE;
        end
      end
      iida_pkg::OP_GEN_DROP: begin
        vld_next = right.valid;
        lo_next  = right_lo;
        hi_next  = right_hi;
      end
      iida_pkg::OP_RES_INC: begin
        if (hit_q) begin
          lo_next = key + ONE;
        end
      end
      iida_pkg::OP_RES_DEC: begin
        if (hit_q) begin
          hi_next = key - ONE;
        end
      end
      iida_pkg::OP_RES_DROP: begin
        if (hit_q || above_q) begin
          vld_next = right.valid;
          lo_next  = right_lo;
          hi_next  = right_hi;
        end
      end
      iida_pkg::OP_RES_SPLIT: begin
        if (hit_q) begin
          hi_next = key - ONE;
        end else if (above_q && left.hit) begin
          vld_next = 1'b1;
          lo_next  = key + ONE;
          hi_next  = left_hi;
        end else if (above_q) begin
          vld_next = left.valid;
          lo_next  = left_lo;
          hi_next  = left_hi;
        end
      end
      iida_pkg::OP_REL_MERGE: begin
        if (is_pm1) begin
          hi_next = right_hi;
        end else if (above_q) begin
          vld_next = right.valid;
          lo_next  = right_lo;
          hi_next  = right_hi;
        end
      end
      iida_pkg::OP_REL_PREV: begin
        if (is_pm1) begin
          hi_next = key;
        end
      end
      iida_pkg::OP_REL_NEXT: begin
        if (is_p) begin
          lo_next = key;
        end
      end
      iida_pkg::OP_REL_INS: begin
        if (is_p) begin
          vld_next = 1'b1;
          lo_next  = key;
          hi_next  = key;
        end else if (above_q) begin
          vld_next = left.valid;
          lo_next  = left_lo;
          hi_next  = left_hi;
        end
      end
      default: ;
    endcase
  end

  // Hold the interval; the first cell starts as the whole ID range
  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= FIRST;
      lo_q <= ONE;
      hi_q <= '1;
    end else begin
      vld  <= vld_next;
      lo_q <= lo_next;
      hi_q <= hi_next;
    end
  end

  // Compare the incoming key against this interval when a word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      below_q <= 1'b0;
      hit_q   <= 1'b0;
      above_q <= 1'b0;
      lo_eq_q <= 1'b0;
      hi_eq_q <= 1'b0;
      nadj_q  <= 1'b0;
      padj_q  <= 1'b0;
    end else if (cmd.capture) begin
      below_q <= vld & (hi_q < key);
      hit_q   <= vld & (lo_q <= key) & (key <= hi_q);
      above_q <= ~vld | (lo_q > key);
      lo_eq_q <= (lo_q == key);
      hi_eq_q <= (hi_q == key);
      nadj_q  <= ({1'b0, lo_q} == ({1'b0, key} + ONE_X));
      padj_q  <= (({1'b0, hi_q} + ONE_X) == {1'b0, key});
    end
  end

endmodule

// ===== src/iida_ctrl.sv =====
// Request decode, update decision and output register for the allocator.
module iida_ctrl #(
  parameter int ID_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [iida_pkg::IN_DATA_W-1:0]    s_tdata,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [iida_pkg::OUT_DATA_W-1:0]   m_tdata,
  output iida_pkg::cell_cmd_t               cmd,
  output logic [ID_BITS-1:0]                cell_key,
  input  iida_pkg::cell_report_t            summary,
  input  logic                              full,
  input  logic                              empty,
  input  logic [ID_BITS-1:0]                low0,
  input  logic [ID_BITS-1:0]                high0
);

  iida_pkg::state_t           state;
  iida_pkg::state_t           state_next;
  iida_pkg::func_t            func_q;
  logic [ID_BITS-1:0]         key_q;
  logic                       ok_q;
  logic [iida_pkg::ID_W-1:0]  rid;
  logic                       ans;
  logic                       tfull;

  iida_pkg::func_t            in_func;
  logic [iida_pkg::ID_W-1:0]  in_id;
  logic [ID_BITS-1:0]         in_key;
  logic                       in_ok;
  logic                       accept;
  logic                       out_free;
  logic                       done;
  iida_pkg::cell_op_t         op_d;
  logic [iida_pkg::ID_W-1:0]  rid_d;
  logic                       ans_d;
  logic                       full_d;

  // Unpack the input word
  assign in_func  = iida_pkg::func_t'(s_tdata[iida_pkg::FUNC_W-1:0]);
  assign in_id    = s_tdata[iida_pkg::FUNC_W +: iida_pkg::ID_W];
  assign in_key   = ID_BITS'(in_id);
  assign in_ok    = (in_id != '0) && ((in_id >> ID_BITS) == '0);
  assign accept   = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;
  assign done     = (state == iida_pkg::ST_EXEC) & out_free;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      iida_pkg::ST_IDLE: if (accept) state_next = iida_pkg::ST_EXEC;
      iida_pkg::ST_EXEC: if (out_free) state_next = iida_pkg::ST_IDLE;
      default: state_next = iida_pkg::ST_IDLE;
    endcase
  end

  // Choose the row update and the result from the cells' findings
  always_comb begin
    op_d   = iida_pkg::OP_NONE;
    rid_d  = '0;
    ans_d  = 1'b0;
    full_d = 1'b0;
    unique case (func_q)
      iida_pkg::FN_GENERATE: begin
        if (!empty) begin
          rid_d = iida_pkg::ID_W'(low0);
          ans_d = 1'b1;
          op_d  = (low0 < high0) ? iida_pkg::OP_GEN_INC : iida_pkg::OP_GEN_DROP;
        end
      end
      iida_pkg::FN_QUERY: begin
        ans_d = ~(ok_q & summary.hit);
      end
      iida_pkg::FN_RESERVE: begin
        if (ok_q && summary.hit) begin
          if (summary.lo_hit) begin
            op_d  = summary.hi_hit ? iida_pkg::OP_RES_DROP : iida_pkg::OP_RES_INC;
            ans_d = 1'b1;
          end else if (summary.hi_hit) begin
            op_d  = iida_pkg::OP_RES_DEC;
            ans_d = 1'b1;
          end else if (full) begin
            full_d = 1'b1;
          end else begin
            op_d  = iida_pkg::OP_RES_SPLIT;
            ans_d = 1'b1;
          end
        end
      end
      iida_pkg::FN_RELEASE: begin
        if (ok_q && !summary.hit) begin
          if (summary.prev_ok && summary.next_ok) begin
            op_d  = iida_pkg::OP_REL_MERGE;
            ans_d = 1'b1;
          end else if (summary.prev_ok) begin
            op_d  = iida_pkg::OP_REL_PREV;
            ans_d = 1'b1;
          end else if (summary.next_ok) begin
            op_d  = iida_pkg::OP_REL_NEXT;
            ans_d = 1'b1;
          end else if (full) begin
            full_d = 1'b1;
          end else begin
            op_d  = iida_pkg::OP_REL_INS;
            ans_d = 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  // Outputs of the state machine
  always_comb begin
    s_tready    = (state == iida_pkg::ST_IDLE);
    cmd.capture = accept;
    cmd.op      = done ? op_d : iida_pkg::OP_NONE;
    cell_key    = (state == iida_pkg::ST_IDLE) ? in_key : key_q;
  end

  assign m_tdata = {{(iida_pkg::OUT_DATA_W - iida_pkg::ID_W - 2){1'b0}}, tfull, ans, rid};

  // Advance the state machine and hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= iida_pkg::ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (done) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // Latch the request and the result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q <= in_func;
      key_q  <= in_key;
      ok_q   <= in_ok;
    end
    if (done) begin
      rid   <= rid_d;
      ans   <= ans_d;
      tfull <= full_d;
    end
  end

endmodule

// ===== src/interval_id_allocator.sv =====
// Interval ID allocator top level: a row of interval cells and its controller.
// A taken word is executed in the execute state, which loads the registered result word.
// No new word is taken until the last one is done; the cells compare in the cycle a word
// is taken and apply the trim, split, merge or shift in the execute state.
// A waiting output word holds the update until it is taken.
// Reset: the row holds one free interval [1, 2^ID_BITS-1], output is empty.
module interval_id_allocator #(
  parameter int MAX_INTERVALS = 64,
  parameter int ID_BITS       = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [iida_pkg::IN_DATA_W-1:0]   s_tdata,  // func[1:0], id[33:2], zero pad
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [iida_pkg::OUT_DATA_W-1:0]  m_tdata   // result_id[31:0], answer, table_full, pad
);

  iida_pkg::cell_cmd_t     cmd;
  logic [ID_BITS-1:0]      cell_key;
  iida_pkg::cell_link_t    links [MAX_INTERVALS];
  logic [ID_BITS-1:0]      los   [MAX_INTERVALS];
  logic [ID_BITS-1:0]      his   [MAX_INTERVALS];
  iida_pkg::cell_report_t  reps  [MAX_INTERVALS];
  logic [MAX_INTERVALS-1:0] vld_vec;
  logic [MAX_INTERVALS-1:0] hit_vec;
  logic [MAX_INTERVALS-1:0] lo_vec;
  logic [MAX_INTERVALS-1:0] hi_vec;
  logic [MAX_INTERVALS-1:0] prev_vec;
  logic [MAX_INTERVALS-1:0] next_vec;
  iida_pkg::cell_report_t  summary;

  // Build the row; the ends see an empty neighbour
  for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
    iida_pkg::cell_link_t left_l;
    iida_pkg::cell_link_t right_l;
    logic [ID_BITS-1:0]   left_lo;
    logic [ID_BITS-1:0]   left_hi;
    logic [ID_BITS-1:0]   right_lo;
    logic [ID_BITS-1:0]   right_hi;

    if (i == 0) begin : g_lend
      assign left_l  = '{valid: 1'b0, below: 1'b1, hit: 1'b0, above: 1'b0};
      assign left_lo = '0;
      assign left_hi = '0;
    end else begin : g_lnb
      assign left_l  = links[i-1];
      assign left_lo = los[i-1];
      assign left_hi = his[i-1];
    end

    if (i == MAX_INTERVALS - 1) begin : g_rend
      assign right_l  = '{valid: 1'b0, below: 1'b0, hit: 1'b0, above: 1'b1};
      assign right_lo = '0;
      assign right_hi = '0;
    end else begin : g_rnb
      assign right_l  = links[i+1];
      assign right_lo = los[i+1];
      assign right_hi = his[i+1];
    end

    iida_cell #(
      .ID_BITS (ID_BITS),
      .FIRST   (i == 0)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .cmd      (cmd),
      .key      (cell_key),
      .left     (left_l),
      .left_lo  (left_lo),
      .left_hi  (left_hi),
      .right    (right_l),
      .right_lo (right_lo),
      .right_hi (right_hi),
      .link     (links[i]),
      .lo       (los[i]),
      .hi       (his[i]),
      .report   (reps[i])
    );

    assign vld_vec[i]  = links[i].valid;
    assign hit_vec[i]  = reps[i].hit;
    assign lo_vec[i]   = reps[i].lo_hit;
    assign hi_vec[i]   = reps[i].hi_hit;
    assign prev_vec[i] = reps[i].prev_ok;
    assign next_vec[i] = reps[i].next_ok;
  end

  // Gather the row's findings
  assign summary.hit     = |hit_vec;
  assign summary.lo_hit  = |lo_vec;
  assign summary.hi_hit  = |hi_vec;
  assign summary.prev_ok = |prev_vec;
  assign summary.next_ok = |next_vec;

  iida_ctrl #(
    .ID_BITS (ID_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cmd      (cmd),
    .cell_key (cell_key),
    .summary  (summary),
    .full     (vld_vec[MAX_INTERVALS-1]),
    .empty    (~vld_vec[0]),
    .low0     (los[0]),
    .high0    (his[0])
  );

  // Occupied cells always form an unbroken run from the first cell
  a_valid_prefix: assert property (@(posedge clk) disable iff (rst)
    (((vld_vec >> 1) & ~vld_vec) == '0))
    else $error("interval row has a gap");

  // Free intervals are disjoint, so at most one cell can hold the key
  a_single_hit: assert property (@(posedge clk) disable iff (rst)
    $onehot0(hit_vec))
    else $error("key found in more than one interval");

  // The release neighbours are unique
  a_single_prev: assert property (@(posedge clk) disable iff (rst)
    $onehot0(prev_vec) && $onehot0(next_vec))
    else $error("more than one merge candidate");

  // A taken word blocks the input until its update is applied
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input taken during execute");

  // A refused split or insert never reports success
  a_full_refused: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[iida_pkg::ID_W+1]) |-> !m_tdata[iida_pkg::ID_W])
    else $error("table_full with answer set");

endmodule

// ===== bench/interval_id_allocator_tb.sv =====
// Self-checking bench for the interval ID allocator: directed and random requests.
module interval_id_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROW_DEPTH = 64;
  localparam int ID_WINDOW = 300;

  // One predicted response word, with the request that caused it
  typedef struct {
    iida_pkg::func_t req_func;
    bit [31:0]       req_id;
    bit [31:0]       result_id;
    bit              answer;
    bit              table_full;
  } outcome_t;

  // Free-interval table kept alongside the block, plus responses still owed
  class free_list_scoreboard;
    bit [63:0]    lo [ROW_DEPTH];
    bit [63:0]    hi [ROW_DEPTH];
    int           count;
    outcome_t     awaited[$];
    int           errors;

    function new();
      foreach (lo[i]) begin
        lo[i] = '0;
        hi[i] = '0;
      end
      lo[0]  = 64'd1;
      hi[0]  = 64'hFFFF_FFFF;
      count  = 1;
      errors = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    task log_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    // Index of the interval holding v, or count when v is in use
    function int locate(bit [63:0] v);
      for (int i = 0; i < count; i++)
        if (lo[i] <= v && v <= hi[i]) return i;
      return count;
    endfunction

    // Remove entry k and close the gap
    function void drop_entry(int k);
      for (int i = k; i + 1 < count; i++) begin
        lo[i] = lo[i+1];
        hi[i] = hi[i+1];
      end
      count--;
    endfunction

    // Open a slot at k by shifting the entries above it
    function void insert_entry(int k, bit [63:0] new_lo, bit [63:0] new_hi);
      for (int i = count; i > k; i--) begin
        lo[i] = lo[i-1];
        hi[i] = hi[i-1];
      end
      lo[k] = new_lo;
      hi[k] = new_hi;
      count++;
    endfunction

    // Apply one accepted request to the table and queue the response it owes
    function void take_request(iida_pkg::func_t f, bit [31:0] id);
      outcome_t  o;
      bit [63:0] v;
      bit        in_range;
      int        k;
      int        p;
      bit        prev_adj;
      bit        next_adj;
      o.req_func   = f;
      o.req_id     = id;
      o.result_id  = '0;
      o.answer     = 1'b0;
      o.table_full = 1'b0;
      v        = {32'b0, id};
      in_range = (id != 32'd0);
      case (f)
        iida_pkg::FN_GENERATE: begin
          if (count > 0) begin
            o.result_id = lo[0][31:0];
            o.answer    = 1'b1;
            if (lo[0] < hi[0]) lo[0]++;
            else drop_entry(0);
          end
        end
        iida_pkg::FN_QUERY: begin
          o.answer = !(in_range && locate(v) < count);
        end
        iida_pkg::FN_RESERVE: begin
          k = in_range ? locate(v) : count;
          if (k < count) begin
            if (lo[k] == v) begin
              if (lo[k] == hi[k]) drop_entry(k);
              else lo[k]++;
              o.answer = 1'b1;
            end else if (hi[k] == v) begin
              hi[k]--;
              o.answer = 1'b1;
            end else if (count >= ROW_DEPTH) begin
              o.table_full = 1'b1;
            end else begin
              insert_entry(k + 1, v + 1, hi[k]);
              hi[k]    = v - 1;
              o.answer = 1'b1;
            end
          end
        end
        default: begin
          if (in_range && locate(v) >= count) begin
            p = 0;
            while (p < count && hi[p] < v) p++;
            prev_adj = 1'b0;
            next_adj = 1'b0;
            if (p > 0) prev_adj = (hi[p-1] + 1 == v);
            if (p < count) next_adj = (lo[p] - 1 == v);
            if (prev_adj && next_adj) begin
              hi[p-1] = hi[p];
              drop_entry(p);
              o.answer = 1'b1;
            end else if (prev_adj) begin
              hi[p-1]  = v;
              o.answer = 1'b1;
            end else if (next_adj) begin
              lo[p]    = v;
              o.answer = 1'b1;
            end else if (count >= ROW_DEPTH) begin
              o.table_full = 1'b1;
            end else begin
              insert_entry(p, v, v);
              o.answer = 1'b1;
            end
          end
        end
      endcase
      awaited = {awaited, o};
    endfunction

    // Compare a returned word with the oldest prediction
    task match_outcome(bit [31:0] rid, bit ans, bit full);
      outcome_t e;
      if (awaited.size() == 0) begin
        log_mismatch($sformatf("unexpected word result_id=%h answer=%b table_full=%b",
                               rid, ans, full));
        return;
      end
      e = awaited.pop_front();
      if (rid != e.result_id)
        log_mismatch($sformatf("%s id=%h: result_id %h, want %h",
                               e.req_func.name(), e.req_id, rid, e.result_id));
      if (ans != e.answer)
        log_mismatch($sformatf("%s id=%h: answer %b, want %b",
                               e.req_func.name(), e.req_id, ans, e.answer));
      if (full != e.table_full)
        log_mismatch($sformatf("%s id=%h: table_full %b, want %b",
                               e.req_func.name(), e.req_id, full, e.table_full));
    endtask
  endclass

  logic                             clk;
  logic                             rst;
  logic                             s_tvalid;
  logic                             s_tready;
  logic [iida_pkg::IN_DATA_W-1:0]   s_tdata;
  logic                             m_tvalid;
  logic                             m_tready;
  logic [iida_pkg::OUT_DATA_W-1:0]  m_tdata;

  free_list_scoreboard book;
  bit                  steady;       // no idling on either side while set
  bit                  hold_output;  // sink holds off for a long stretch

  interval_id_allocator uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Known values before the first edge
  initial begin
    rst         = 1'b1;
    s_tvalid    = 1'b0;
    s_tdata     = '0;
    m_tready    = 1'b0;
    steady      = 1'b0;
    hold_output = 1'b0;
    book        = new();
  end

  // Offer one request word, with random gaps ahead of it, and wait for acceptance
  task automatic send_word(iida_pkg::func_t f, bit [31:0] id);
    if (!steady) begin
      while ($urandom_range(99) < 38) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, id, f};
    do @(posedge clk); while (!s_tready);
    book.take_request(f, id);
  endtask

  // Hold the input quiet until every owed response has returned
  task automatic drain_results();
    while (book.pending() != 0) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // IDs mostly from a small window so intervals fragment, some near the top
  function automatic bit [31:0] draw_id();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 72) return $urandom_range(ID_WINDOW, 1);
    if (r < 82) return 32'hFFFF_FFFF - $urandom_range(40);
    if (r < 94) return $urandom;
    return 32'd0;
  endfunction

  // Request mix leaning towards reserve or towards release
  function automatic iida_pkg::func_t draw_func(bit lean_reserve);
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return iida_pkg::FN_GENERATE;
    if (r < 25) return iida_pkg::FN_QUERY;
    if (r < 45) return lean_reserve ? iida_pkg::FN_RELEASE : iida_pkg::FN_RESERVE;
    return lean_reserve ? iida_pkg::FN_RESERVE : iida_pkg::FN_RELEASE;
  endfunction

  // Sink: random back-pressure, plus one long hold-off on request
  initial begin : sink
    int held;
    held = 0;
    forever begin
      @(posedge clk);
      if (hold_output) begin
        m_tready <= 1'b0;
        held++;
        if (held >= 150) begin
          hold_output = 1'b0;
          held        = 0;
        end
      end else begin
        m_tready <= steady || ($urandom_range(99) >= 38);
      end
    end
  end

  // Check every response word the sink takes
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      book.match_outcome(m_tdata[31:0], m_tdata[32], m_tdata[33]);
  end

  // Stimulus
  initial begin : stimulus
    bit lean_reserve;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Invalid ID zero, generate from a fresh table
    send_word(iida_pkg::FN_QUERY, 32'd0);
    send_word(iida_pkg::FN_RESERVE, 32'd0);
    send_word(iida_pkg::FN_RELEASE, 32'd0);
    send_word(iida_pkg::FN_GENERATE, 32'hFFFF_FFFF);
    send_word(iida_pkg::FN_GENERATE, 32'd0);
    send_word(iida_pkg::FN_QUERY, 32'd1);
    send_word(iida_pkg::FN_QUERY, 32'h5555_5555);
    // Release of a free ID is refused; insert below, then merge
    send_word(iida_pkg::FN_RELEASE, 32'hAAAA_AAAA);
    send_word(iida_pkg::FN_RELEASE, 32'd1);
    send_word(iida_pkg::FN_RELEASE, 32'd2);
    // Split, then generate empties the lowest interval
    send_word(iida_pkg::FN_RESERVE, 32'd3);
    send_word(iida_pkg::FN_GENERATE, 32'd0);
    send_word(iida_pkg::FN_GENERATE, 32'd0);
    // Trim the top, release above the last interval, merge back
    send_word(iida_pkg::FN_RESERVE, 32'hFFFF_FFFF);
    send_word(iida_pkg::FN_RESERVE, 32'hFFFF_FFFE);
    send_word(iida_pkg::FN_RELEASE, 32'hFFFF_FFFF);
    send_word(iida_pkg::FN_RELEASE, 32'hFFFF_FFFE);
    // Split in the middle, refuse a second reserve, extend both ways
    send_word(iida_pkg::FN_RESERVE, 32'd100);
    send_word(iida_pkg::FN_RESERVE, 32'd100);
    send_word(iida_pkg::FN_RESERVE, 32'd101);
    send_word(iida_pkg::FN_RELEASE, 32'd100);
    send_word(iida_pkg::FN_RELEASE, 32'd101);
    send_word(iida_pkg::FN_RESERVE, 32'd200);
    send_word(iida_pkg::FN_RESERVE, 32'd201);
    send_word(iida_pkg::FN_RELEASE, 32'd201);
    // Reserve empties a single-ID interval
    send_word(iida_pkg::FN_RESERVE, 32'd5);
    send_word(iida_pkg::FN_RESERVE, 32'd4);

    // Random phases alternate between fragmenting and coalescing the table
    for (int phase = 0; phase < 8; phase++) begin
      lean_reserve = (phase % 2 == 0);
      steady       = (phase == 4);
      for (int n = 0; n < 196; n++) begin
        if (phase == 1 && n == 60) hold_output = 1'b1;
        send_word(draw_func(lean_reserve), draw_id());
      end
      if (phase == 3) drain_results();
    end
    steady = 1'b0;

    // Let the last responses come back
    s_tvalid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (book.errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

  // Give up on a hung run
  initial begin : watchdog
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
